/* src/nnds_pkg.sv */
// shared types, constants and the normalization table for the downscaler
`default_nettype none
package nnds_pkg;

    localparam int MAX_DIMENSION_DEF      = 4096;
    localparam int NORM_FRACTION_BITS_DEF = 15;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = CFG_W'(1280);
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = CFG_W'(720);
    localparam logic [CFG_W-1:0] DST_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] DST_HEIGHT_RST = CFG_W'(640);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 96;
    localparam int POS_OUT_W = 12;
    localparam int OFF_OUT_W = 24;
    localparam int NORM_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] dst_width;
        logic [CFG_W-1:0] dst_height;
    } cfg_t;

    typedef struct packed {
        logic keep;
        logic done;
    } sel_flags_t;

    typedef logic [255:0][NORM_W-1:0] norm_lut_t;

    // round(v * 2^frac / 255) for every byte value, built at elaboration
    function automatic norm_lut_t norm_table(input int frac_bits);
        norm_lut_t         lut;
        longint unsigned   num;
        for (int v = 0; v < 256; v++) begin
            num    = (longint'(v) << (frac_bits + 1)) + 64'd255;
            lut[v] = NORM_W'(num / 64'd510);
        end
        return lut;
    endfunction

endpackage
`default_nettype wire

/* src/nnds_select.sv */
// source/target counters and accumulators deciding which source pixels are kept
`default_nettype none
module nnds_select #(
    parameter int MAX_DIMENSION = nnds_pkg::MAX_DIMENSION_DEF,
    localparam int TGT_W = $clog2(MAX_DIMENSION + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic                 frame_start,
    input  wire nnds_pkg::cfg_t       cfg,
    output nnds_pkg::sel_flags_t      flags,
    output logic [TGT_W-1:0]          row,
    output logic [TGT_W-1:0]          col
);

    localparam int SRC_W = $clog2(MAX_DIMENSION);
    localparam int CMP_W = ((TGT_W > nnds_pkg::CFG_W) ? TGT_W : nnds_pkg::CFG_W) + 1;
    localparam int ACC_W = SRC_W + nnds_pkg::CFG_W + 1;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIMENSION);

    logic [SRC_W-1:0] sc_reg, sr_reg, sc, sr, sc_next, sr_next;
    logic [TGT_W-1:0] tc_reg, tr_reg, tc, tr, tc_next, tr_next;
    logic [ACC_W-1:0] cacc_reg, cbase_reg, racc_reg, rbase_reg;
    logic [ACC_W-1:0] cacc, cbase, racc, rbase;
    logic [ACC_W-1:0] cacc_next, cbase_next, racc_next, rbase_next;

    logic [CMP_W-1:0] src_w_c, src_h_c, dst_w_c, dst_h_c, sc_inc, sr_inc;
    logic             row_sel, col_sel, row_end, frame_end;

    // frame start clears the counters ahead of this pixel
    always_comb begin
        sc    = frame_start ? '0 : sc_reg;
        sr    = frame_start ? '0 : sr_reg;
        tc    = frame_start ? '0 : tc_reg;
        tr    = frame_start ? '0 : tr_reg;
        cacc  = frame_start ? '0 : cacc_reg;
        cbase = frame_start ? '0 : cbase_reg;
        racc  = frame_start ? '0 : racc_reg;
        rbase = frame_start ? '0 : rbase_reg;
    end

    assign src_w_c = CMP_W'(cfg.src_width);
    assign src_h_c = CMP_W'(cfg.src_height);
    assign dst_w_c = CMP_W'(cfg.dst_width);
    assign dst_h_c = CMP_W'(cfg.dst_height);
    assign sc_inc  = CMP_W'(sc) + CMP_W'(1);
    assign sr_inc  = CMP_W'(sr) + CMP_W'(1);

    assign row_sel = (CMP_W'(tr) < dst_h_c) && (CMP_W'(tr) < MAX_DIM_C)
                  && (racc < rbase + ACC_W'(cfg.dst_height));
    assign col_sel = (CMP_W'(tc) < dst_w_c) && (CMP_W'(tc) < MAX_DIM_C)
                  && (cacc < cbase + ACC_W'(cfg.dst_width));
    assign row_end   = (sc_inc >= src_w_c) || (sc_inc >= MAX_DIM_C);
    assign frame_end = (sr_inc >= src_h_c) || (sr_inc >= MAX_DIM_C);

    assign flags.keep = row_sel && col_sel;
    assign flags.done = (CMP_W'(tr) + CMP_W'(1) == dst_h_c)
                     && (CMP_W'(tc) + CMP_W'(1) == dst_w_c);
    assign row = tr;
    assign col = tc;

    always_comb begin
        sc_next    = sc;
        sr_next    = sr;
        tc_next    = tc;
        tr_next    = tr;
        cacc_next  = cacc;
        cbase_next = cbase;
        racc_next  = racc;
        rbase_next = rbase;
        if (flags.keep) begin
            tc_next   = tc + TGT_W'(1);
            cacc_next = cacc + ACC_W'(cfg.src_width);
        end
        if (!row_end) begin
            sc_next    = sc + SRC_W'(1);
            cbase_next = cbase + ACC_W'(cfg.dst_width);
        end else begin
            sc_next    = '0;
            cbase_next = '0;
            tc_next    = '0;
            cacc_next  = '0;
            if (frame_end) begin
                sr_next    = '0;
                tr_next    = '0;
                racc_next  = '0;
                rbase_next = '0;
            end else begin
                sr_next    = sr + SRC_W'(1);
                rbase_next = rbase + ACC_W'(cfg.dst_height);
                if (row_sel) begin
                    tr_next   = tr + TGT_W'(1);
                    racc_next = racc + ACC_W'(cfg.src_height);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg    <= '0;
            sr_reg    <= '0;
            tc_reg    <= '0;
            tr_reg    <= '0;
            cacc_reg  <= '0;
            cbase_reg <= '0;
            racc_reg  <= '0;
            rbase_reg <= '0;
        end else if (step) begin
            sc_reg    <= sc_next;
            sr_reg    <= sr_next;
            tc_reg    <= tc_next;
            tr_reg    <= tr_next;
            cacc_reg  <= cacc_next;
            cbase_reg <= cbase_next;
            racc_reg  <= racc_next;
            rbase_reg <= rbase_next;
        end
    end

endmodule
`default_nettype wire

/* src/nearest_neighbor_downscale_normalize.sv */
// top level: nearest-neighbour pixel selection, plane offset and q1.15 normalization
// a kept pixel passes through stage 1 and the output register before it shows on m_tvalid
// throughput: one source pixel per cycle while s_tready is high; the counter/accumulator update runs once per beat
// dropped pixels leave no result
// reset: synchronous, active low; clears counters and valid flags, geometry back to
// 1280x720 source and 640x640 destination
`default_nettype none
module nearest_neighbor_downscale_normalize #(
    parameter int MAX_DIMENSION      = nnds_pkg::MAX_DIMENSION_DEF,
    parameter int NORM_FRACTION_BITS = nnds_pkg::NORM_FRACTION_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [nnds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nnds_pkg::CFG_W-1:0]       cfg_data,
    // source pixels
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [nnds_pkg::S_TDATA_W-1:0]   s_tdata,  // red_in, green_in, blue_in
    input  wire logic                             s_tuser,  // frame_start
    // kept pixels
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // dst_row, dst_col, plane_offset, red_norm, green_norm, blue_norm
    output logic [nnds_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tlast   // frame_done
);

    localparam int TGT_W = $clog2(MAX_DIMENSION + 1);
    localparam int POS_W = (TGT_W > nnds_pkg::POS_OUT_W) ? TGT_W : nnds_pkg::POS_OUT_W;
    localparam int PROD_W = TGT_W + nnds_pkg::CFG_W + 1;
    localparam int OFF_W = (PROD_W > nnds_pkg::OFF_OUT_W) ? PROD_W : nnds_pkg::OFF_OUT_W;
    localparam nnds_pkg::norm_lut_t NORM_LUT = nnds_pkg::norm_table(NORM_FRACTION_BITS);

    // geometry registers, always ready
    nnds_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width  <= nnds_pkg::SRC_WIDTH_RST;
            cfg_reg.src_height <= nnds_pkg::SRC_HEIGHT_RST;
            cfg_reg.dst_width  <= nnds_pkg::DST_WIDTH_RST;
            cfg_reg.dst_height <= nnds_pkg::DST_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (nnds_pkg::cfg_reg_t'(cfg_index))
                nnds_pkg::REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data;
                nnds_pkg::REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data;
                nnds_pkg::REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_data;
                nnds_pkg::REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline handshake: stage 1 holds a kept pixel, the output register parts the sides
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_load, s1_move, accept;

    assign out_load = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_load;
    assign s_tready = !s1_valid_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    // selection counters step once per accepted beat
    nnds_pkg::sel_flags_t sel;
    logic [TGT_W-1:0]     sel_row, sel_col;

    nnds_select #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_select (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .frame_start (s_tuser),
        .cfg         (cfg_reg),
        .flags       (sel),
        .row         (sel_row),
        .col         (sel_col)
    );

    // stage 1: position and raw bytes of a kept pixel
    logic [TGT_W-1:0]              s1_row_reg, s1_col_reg;
    logic [nnds_pkg::S_TDATA_W-1:0] s1_rgb_reg;
    logic                          s1_done_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = sel.keep;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && sel.keep) begin
            s1_row_reg  <= sel_row;
            s1_col_reg  <= sel_col;
            s1_rgb_reg  <= s_tdata;
            s1_done_reg <= sel.done;
        end
    end

    // stage 2: planar offset (one small multiply) and table normalization
    logic [POS_W-1:0]               row_ext, col_ext;
    logic [OFF_W-1:0]               off_full;
    logic [nnds_pkg::NORM_W-1:0]    red_norm, green_norm, blue_norm;
    logic [nnds_pkg::M_TDATA_W-1:0] m_data_next;
    logic [nnds_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                           m_last_reg;

    assign row_ext  = POS_W'(s1_row_reg);
    assign col_ext  = POS_W'(s1_col_reg);
    assign off_full = OFF_W'(s1_row_reg) * OFF_W'(cfg_reg.dst_width) + OFF_W'(s1_col_reg);

    assign red_norm   = NORM_LUT[s1_rgb_reg[7:0]];
    assign green_norm = NORM_LUT[s1_rgb_reg[15:8]];
    assign blue_norm  = NORM_LUT[s1_rgb_reg[23:16]];

    assign m_data_next = {blue_norm, green_norm, red_norm,
                          off_full[nnds_pkg::OFF_OUT_W-1:0],
                          col_ext[nnds_pkg::POS_OUT_W-1:0],
                          row_ext[nnds_pkg::POS_OUT_W-1:0]};

    assign m_valid_next = out_load ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_data_reg <= m_data_next;
            m_last_reg <= s1_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

/* src/nnds_checker.sv */
// port-level checks for the downscaler, bound to the top level
`default_nettype none
module nnds_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [nnds_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a fresh result follows an accepted input beat, registered through stage 1 and the output register
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a source beat");

endmodule

bind nearest_neighbor_downscale_normalize nnds_checker u_nnds_checker (.*);
`default_nettype wire

/* sim/tb_nearest_neighbor_downscale_normalize.sv */
// self-checking testbench for the nearest-neighbour downscaler with q1.15 channel normalisation
module tb_nearest_neighbor_downscale_normalize;

    localparam int          MAX_DIM      = 4096;
    localparam int          FRAC_BITS    = 15;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned WIDE_W       = 400;
    localparam int unsigned SETTLE_CYCLES = 8;    // covers the pipeline registers and more
    localparam int unsigned HOLD_CYCLES  = 120;

    // one kept pixel as it should appear on the result stream
    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [23:0] offset;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        done;
    } kept_pixel_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [nnds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [nnds_pkg::CFG_W-1:0]      cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [nnds_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // red_in, green_in, blue_in
    logic                            s_tuser   = 1'b0; // frame_start
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [nnds_pkg::M_TDATA_W-1:0]  m_tdata;          // dst_row, dst_col, plane_offset, r, g, b
    logic                            m_tlast;          // frame_done

    // predicted geometry and scan state
    int unsigned src_w, src_h, dst_w, dst_h;
    int unsigned src_col, src_row, tgt_col, tgt_row;
    int unsigned col_acc, col_base, row_acc, row_base;

    kept_pixel_t pending_pixels[$];
    int unsigned error_count = 0;

    bit          tx_steady    = 1'b0;
    logic        rx_steady    = 1'b0;
    logic        hold_trigger = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned rx_wait      = 0;

    nearest_neighbor_downscale_normalize dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void clear_scan();
        src_col = 0; src_row = 0; tgt_col = 0; tgt_row = 0;
        col_acc = 0; col_base = 0; row_acc = 0; row_base = 0;
    endfunction

    function automatic logic [15:0] q15_of(input logic [7:0] v);
        return 16'(((32'(v) << (FRAC_BITS + 1)) + 32'd255) / 32'd510);
    endfunction

    // advances the scan by one source pixel and queues the kept pixel, if any
    function automatic void predict_selection(input bit fs, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
        bit          row_hit, col_hit;
        kept_pixel_t px;
        if (fs) clear_scan();
        row_hit = tgt_row < dst_h && tgt_row < MAX_DIM && row_acc < row_base + dst_h;
        col_hit = tgt_col < dst_w && tgt_col < MAX_DIM && col_acc < col_base + dst_w;
        if (row_hit && col_hit) begin
            px.row    = tgt_row[11:0];
            px.col    = tgt_col[11:0];
            px.offset = 24'(tgt_row * dst_w + tgt_col);
            px.red    = q15_of(r);
            px.green  = q15_of(g);
            px.blue   = q15_of(b);
            px.done   = (tgt_row + 1 == dst_h) && (tgt_col + 1 == dst_w);
            pending_pixels.push_back(px);
            tgt_col++;
            col_acc += src_w;
        end
        if (src_col + 1 < src_w && src_col + 1 < MAX_DIM) begin
            src_col++;
            col_base += dst_w;
            return;
        end
        // end of a source row
        src_col = 0; col_base = 0; tgt_col = 0; col_acc = 0;
        if (src_row + 1 >= src_h || src_row + 1 >= MAX_DIM) begin
            clear_scan();
            return;
        end
        src_row++;
        row_base += dst_h;
        if (row_hit) begin
            tgt_row++;
            row_acc += src_h;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_beats
        kept_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("beat with nothing pending", m_tdata[11:0], 0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[11:0] !== want.row)
                    report_mismatch("dst_row", m_tdata[11:0], want.row);
                if (m_tdata[23:12] !== want.col)
                    report_mismatch("dst_col", m_tdata[23:12], want.col);
                if (m_tdata[47:24] !== want.offset)
                    report_mismatch("plane_offset", m_tdata[47:24], want.offset);
                if (m_tdata[63:48] !== want.red)
                    report_mismatch("red_norm", m_tdata[63:48], want.red);
                if (m_tdata[79:64] !== want.green)
                    report_mismatch("green_norm", m_tdata[79:64], want.green);
                if (m_tdata[95:80] !== want.blue)
                    report_mismatch("blue_norm", m_tdata[95:80], want.blue);
                if (m_tlast !== want.done)
                    report_mismatch("frame_done", m_tlast, want.done);
            end
        end
    end

    // ---------------------------------------------------------------- result side

    // long hold-off, counted here once triggered
    always @(posedge aclk) begin
        if (hold_trigger) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ready drops for a drawn number of cycles after each beat
    always @(posedge aclk) begin : drive_ready
        int unsigned pause;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (rx_wait != 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else if (m_tvalid && m_tready) begin
            pause = rx_steady ? 0 : $urandom_range(5, 0);
            if (pause != 0) begin
                m_tready <= 1'b0;
                rx_wait  <= pause - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- source side

    function automatic logic [7:0] random_byte();
        case ($urandom_range(7, 0))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    // valid is only lowered ahead of a real gap, so back-to-back beats keep it high
    task automatic send_pixel(input bit fs, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(5, 0);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        predict_selection(fs, r, g, b);
    endtask

    task automatic send_random_pixel(input bit fs);
        send_pixel(fs, random_byte(), random_byte(), random_byte());
    endtask

    // stop sending and let every pending pixel come out, then a few quiet cycles
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_one(input nnds_pkg::cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= nnds_pkg::CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            nnds_pkg::REG_SRC_WIDTH:  src_w = value & 32'h1FFF;
            nnds_pkg::REG_SRC_HEIGHT: src_h = value & 32'h1FFF;
            nnds_pkg::REG_DST_WIDTH:  dst_w = value & 32'h1FFF;
            default:                  dst_h = value & 32'h1FFF;
        endcase
    endtask

    task automatic write_geometry(input int unsigned sw, input int unsigned sh,
                                  input int unsigned dw, input int unsigned dh);
        write_one(nnds_pkg::REG_SRC_WIDTH, sw);
        write_one(nnds_pkg::REG_SRC_HEIGHT, sh);
        write_one(nnds_pkg::REG_DST_WIDTH, dw);
        write_one(nnds_pkg::REG_DST_HEIGHT, dh);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // reset geometry keeps every other source column
    task automatic test_reset_geometry();
        send_pixel(1'b1, 8'd0, 8'd255, 8'd1);
        send_pixel(1'b0, 8'd254, 8'd128, 8'd127);
        send_pixel(1'b0, 8'd255, 8'd0, 8'd255);
        send_pixel(1'b0, 8'd3, 8'd2, 8'd1);
        drain();
    endtask

    // equal size, every pixel kept, channel corner values and frame_done on the last
    task automatic test_channel_extremes();
        write_geometry(3, 2, 3, 2);
        send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'h55, 8'hAA, 8'h0F);
        send_pixel(1'b0, 8'hAA, 8'h55, 8'hF0);
        send_pixel(1'b0, 8'd127, 8'd128, 8'd129);
        send_pixel(1'b0, 8'd1, 8'd254, 8'd2);
        drain();
    endtask

    // zero source width, zero destination and zero source height
    task automatic test_zero_sizes();
        write_geometry(0, 3, 1, 3);
        repeat (3) send_random_pixel(1'b0);
        drain();
        write_geometry(3, 2, 0, 0);
        send_random_pixel(1'b1);
        repeat (2) send_random_pixel(1'b0);
        drain();
        write_geometry(3, 0, 3, 1);
        repeat (3) send_random_pixel(1'b0);
        drain();
    endtask

    // destination larger than source: at most one result per pixel
    task automatic test_upscale();
        write_geometry(2, 2, 4, 3);
        send_random_pixel(1'b1);
        repeat (3) send_random_pixel(1'b0);
        drain();
    endtask

    // frame_start partway through a frame clears the scan
    task automatic test_frame_restart();
        write_geometry(4, 3, 2, 2);
        send_random_pixel(1'b1);
        repeat (2) send_random_pixel(1'b0);
        send_random_pixel(1'b1);
        repeat (2) send_random_pixel(1'b0);
        drain();
    endtask

    // long row at a large width with a slight shrink, then a wrap into the next frame
    task automatic test_widest_row();
        write_geometry(WIDE_W, 1, WIDE_W - 3, 1);
        tx_steady = 1'b1;
        send_random_pixel(1'b1);
        repeat (WIDE_W + 2) send_random_pixel(1'b0);
        tx_steady = 1'b0;
        drain();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        write_geometry(8, 8, 8, 8);
        hold_trigger <= 1'b1;
        @(posedge aclk);
        hold_trigger <= 1'b0;
        tx_steady = 1'b1;
        send_random_pixel(1'b1);
        repeat (79) send_random_pixel(1'b0);
        tx_steady = 1'b0;
        drain();
    endtask

    // small random geometries, mostly whole frames, some truncated or restarted
    task automatic test_random_frames();
        int unsigned sw, sh, dw, dh, frames, len, fs_at, kind, sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sw = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
            sh = $urandom_range(6, 1);
            case ($urandom_range(2, 0))
                0:       dw = sw;
                1:       dw = 1;
                default: dw = $urandom_range(sw, 1);
            endcase
            case ($urandom_range(2, 0))
                0:       dh = sh;
                1:       dh = 1;
                default: dh = $urandom_range(sh, 1);
            endcase
            drain();
            write_geometry(sw, sh, dw, dh);
            tx_steady = ($urandom_range(3, 0) == 0);
            rx_steady <= ($urandom_range(3, 0) == 0);
            frames = $urandom_range(5, 2);
            repeat (frames) begin
                kind  = $urandom_range(9, 0);
                len   = sw * sh;
                fs_at = 0;
                if (kind == 0) begin
                    len = $urandom_range(len, 1);         // cut short
                end else if (kind == 1) begin
                    fs_at = $urandom_range(len - 1, 0);   // restart partway
                end
                for (int unsigned i = 0; i < len; i++) begin
                    send_random_pixel((kind == 2) ? 1'b0 : (i == fs_at));
                    sent++;
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        drain();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        src_w = 1280; src_h = 720; dst_w = 640; dst_h = 640;
        clear_scan();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_geometry();
        test_channel_extremes();
        test_zero_sizes();
        test_upscale();
        test_frame_restart();
        test_widest_row();
        test_backpressure();
        test_random_frames();

        if (pending_pixels.size() != 0)
            report_mismatch("pixels still pending", 0, pending_pixels.size());
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* nearest_neighbor_downscale_normalize.f */
src/nnds_pkg.sv
src/nnds_select.sv
src/nearest_neighbor_downscale_normalize.sv
src/nnds_checker.sv
sim/tb_nearest_neighbor_downscale_normalize.sv
